### rtl/y2r_pkg.sv
// Package for the 4:2:0 block to RGB565 converter.
// Holds the fixed-point widths, BT.601 coefficients, offset struct and clamp/pack helpers.
// No dependencies.
package y2r_pkg;

    // Width of every intermediate fixed-point term; all sums fit in 24 signed bits.
    localparam int SUM_W = 24;
    localparam int FRAC_W = 12;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [7:0] sample_t;
    typedef logic [15:0] rgb565_t;

    // BT.601 coefficients in 12-bit fixed point.
    localparam sum_t COEF_Y  = sum_t'(4767);
    localparam sum_t COEF_RV = sum_t'(6537);
    localparam sum_t COEF_GV = sum_t'(3330);
    localparam sum_t COEF_GU = sum_t'(1605);
    localparam sum_t COEF_BU = sum_t'(8261);

    localparam logic signed [8:0] LUMA_OFS   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFS = 9'sd128;

    // Chroma contributions shared by the four pixels of a block.
    typedef struct packed {
        sum_t r_off;
        sum_t g_off;
        sum_t b_off;
    } chroma_off_t;

    // Floor shift by the fraction width, then saturate to 0..255.
    function automatic sample_t clamp_chan(input sum_t sum);
        sample_t res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (|sum[SUM_W-2:FRAC_W+8]) begin
            res = '1;
        end else begin
            res = sum[FRAC_W+7:FRAC_W];
        end
        return res;
    endfunction

    // Pack the top bits of each channel into an RGB565 word.
    function automatic rgb565_t pack_rgb565(input sample_t r, input sample_t g, input sample_t b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

### rtl/y2r_blk_if.sv
// Input channel interface: one 2x2 block of 4:2:0 samples per transaction.
// Depends on y2r_pkg for the sample type.
interface y2r_blk_if import y2r_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t luma_top_left;
    sample_t luma_top_right;
    sample_t luma_bottom_left;
    sample_t luma_bottom_right;
    sample_t chroma_u;
    sample_t chroma_v;

    modport source (
        output valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        input  ready
    );

    modport sink (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        output ready
    );
endinterface

### rtl/y2r_pix_if.sv
// Output channel interface: four RGB565 pixels per transaction.
// Depends on y2r_pkg for the pixel type.
interface y2r_pix_if import y2r_pkg::*; ();
    logic    valid;
    logic    ready;
    rgb565_t pixel_top_left;
    rgb565_t pixel_top_right;
    rgb565_t pixel_bottom_left;
    rgb565_t pixel_bottom_right;

    modport source (
        output valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
               pixel_bottom_right,
        input  ready
    );

    modport sink (
        input  valid, pixel_top_left, pixel_top_right, pixel_bottom_left,
               pixel_bottom_right,
        output ready
    );
endinterface

### rtl/y2r_lane.sv
// One pixel lane: luma multiply, channel sums, clamp and RGB565 pack over four stages.
// Depends on y2r_pkg; chroma offsets arrive from the top level aligned to stage 2.
module y2r_lane
    import y2r_pkg::*;
(
    input  logic        clk,
    input  logic        advance,
    input  sample_t     luma,
    input  chroma_off_t chroma_off,
    output rgb565_t     pixel
);

    sum_t    lum_s1_reg, lum_s1_next;
    sum_t    lum_s2_reg;
    sum_t    r_sum_reg, r_sum_next;
    sum_t    g_sum_reg, g_sum_next;
    sum_t    b_sum_reg, b_sum_next;
    rgb565_t pixel_reg, pixel_next;

    // Stage 1: luma term (y - 16) * 4767.
    always_comb
    begin
        lum_s1_next = sum_t'(signed'({1'b0, luma}) - LUMA_OFS) * COEF_Y;
    end

    // Stage 3: add the chroma contributions to the luma term.
    always_comb
    begin
        r_sum_next = lum_s2_reg + chroma_off.r_off;
        g_sum_next = lum_s2_reg - chroma_off.g_off;
        b_sum_next = lum_s2_reg + chroma_off.b_off;
    end

    // Stage 4: saturate each channel and pack.
    always_comb
    begin
        pixel_next = pack_rgb565(clamp_chan(r_sum_reg), clamp_chan(g_sum_reg),
                                 clamp_chan(b_sum_reg));
    end

    // Payload registers move only when the pipeline advances.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lum_s1_reg <= lum_s1_next;
            lum_s2_reg <= lum_s1_reg;
            r_sum_reg  <= r_sum_next;
            g_sum_reg  <= g_sum_next;
            b_sum_reg  <= b_sum_next;
            pixel_reg  <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

### rtl/yuv420_block_to_rgb565.sv
// Top level of the 4:2:0 block to RGB565 converter: chroma pipeline, four lanes, handshake.
// Depends on y2r_pkg, y2r_blk_if, y2r_pix_if and y2r_lane.
//
//   Channel  Role    Transaction
//   blk      sink    four luma samples plus shared U and V of one 2x2 block
//   pix      source  four RGB565 pixels of the same block
//
// Four register stages: multiply, chroma sum, channel sums, clamp and pack. Output valid
// rises once a transaction reaches the clamp and pack register, the last stage. One
// block is accepted every cycle while the output is taken or empty. Reset clears only
// the stage valid bits. When the output holds an untaken result every stage freezes
// together, so nothing is dropped or repeated.
module yuv420_block_to_rgb565
    import y2r_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    y2r_blk_if.sink   blk,
    y2r_pix_if.source pix
);

    logic        advance;
    logic [3:0]  valid_reg, valid_next;
    sum_t        rv_s1_reg, rv_s1_next;
    sum_t        gv_s1_reg, gv_s1_next;
    sum_t        gu_s1_reg, gu_s1_next;
    sum_t        bu_s1_reg, bu_s1_next;
    chroma_off_t off_s2_reg, off_s2_next;

    // The whole pipeline stalls only when the output register holds an untaken result.
    assign advance   = !valid_reg[3] || pix.ready;
    assign blk.ready = advance;

    // Valid bits shift with the data.
    always_comb
    begin
        valid_next = {valid_reg[2:0], blk.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: chroma products.
    always_comb
    begin
        rv_s1_next = sum_t'(signed'({1'b0, blk.chroma_v}) - CHROMA_OFS) * COEF_RV;
        gv_s1_next = sum_t'(signed'({1'b0, blk.chroma_v}) - CHROMA_OFS) * COEF_GV;
        gu_s1_next = sum_t'(signed'({1'b0, blk.chroma_u}) - CHROMA_OFS) * COEF_GU;
        bu_s1_next = sum_t'(signed'({1'b0, blk.chroma_u}) - CHROMA_OFS) * COEF_BU;
    end

    // Stage 2: combine the green terms; red and blue pass through.
    always_comb
    begin
        off_s2_next.r_off = rv_s1_reg;
        off_s2_next.g_off = gv_s1_reg + gu_s1_reg;
        off_s2_next.b_off = bu_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rv_s1_reg  <= rv_s1_next;
            gv_s1_reg  <= gv_s1_next;
            gu_s1_reg  <= gu_s1_next;
            bu_s1_reg  <= bu_s1_next;
            off_s2_reg <= off_s2_next;
        end
    end

    // Four pixel lanes share the chroma offsets.
    y2r_lane u_lane_tl (
        .clk        (clk),
        .advance    (advance),
        .luma       (blk.luma_top_left),
        .chroma_off (off_s2_reg),
        .pixel      (pix.pixel_top_left)
    );

    y2r_lane u_lane_tr (
        .clk        (clk),
        .advance    (advance),
        .luma       (blk.luma_top_right),
        .chroma_off (off_s2_reg),
        .pixel      (pix.pixel_top_right)
    );

    y2r_lane u_lane_bl (
        .clk        (clk),
        .advance    (advance),
        .luma       (blk.luma_bottom_left),
        .chroma_off (off_s2_reg),
        .pixel      (pix.pixel_bottom_left)
    );

    y2r_lane u_lane_br (
        .clk        (clk),
        .advance    (advance),
        .luma       (blk.luma_bottom_right),
        .chroma_off (off_s2_reg),
        .pixel      (pix.pixel_bottom_right)
    );

    assign pix.valid = valid_reg[3];

    // Input backpressure only comes from a blocked output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !blk.ready |-> (pix.valid && !pix.ready))
        else $error("input stalled without a blocked output");

    // A frozen pipeline keeps all its valid bits.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // An accepted transaction reaches stage 1.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (blk.valid && blk.ready) |=> valid_reg[0])
        else $error("accepted transaction lost at stage 1");

    // Advancing with no input leaves a bubble.
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !blk.valid) |=> !valid_reg[0])
        else $error("transaction invented at stage 1");

endmodule
